[hdl/tcps_pkg.sv]
// Shared types and constants of the three-channel square-wave synthesizer.
package tcps_pkg;

   localparam int TICK_W   = 8;
   localparam int PROD_W   = 13;
   localparam int QUOT_W   = 5;
   localparam int SAMPLE_W = 7;
   localparam int DIV_W    = 16;
   localparam int DCNT_W   = 4;

   localparam logic [PROD_W-1:0]   CHANNEL_AMP  = 13'd28;
   localparam logic [7:0]          DECODE_MASK  = 8'h9F;
   localparam logic [7:0]          DECODE_MATCH = 8'h8E;
   localparam logic [1:0]          PORT_CTRL    = 2'd3;
   localparam logic [DIV_W-1:0]    MIN_DIVISOR  = 16'd2;
   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE   = 7'd84;
   localparam logic [DCNT_W-1:0]   DIV_STEPS    = DCNT_W'(PROD_W);

   localparam logic [TICK_W-1:0]   TICKS_RESET  = 8'd112;
   localparam logic                CSR_TICKS    = 1'b0;
   localparam logic                CSR_ENABLE   = 1'b1;

   typedef struct packed {
      logic port_wr;
      logic sample_start;
      logic tick;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

[hdl/three_channel_pit_square_synth_top.sv]
// Top level of the three-channel square-wave synthesizer with its configuration registers.
//
//  channel | direction | ports                                         | handshake
//  req     | in        | req_type, req_port_addr_low, req_write_byte   | req_valid / req_stall
//  rsp     | out       | rsp_sample_value                              | rsp_valid / rsp_stall
//  config  | in        | paddr, pwdata, prdata                         | psel / penable / pready
//
// A port write item is applied when it is taken. A sample item runs the counter ticks in
// the channel lanes, then a 13-step restoring divide per lane.
// Reset is synchronous and active high; it clears lane control state, rsp_valid and the CSRs.
// A stalled result holds in the output register; the next item is taken meanwhile, and
// a sample item waits at its end until the output register is free.
module three_channel_pit_square_synth_top import tcps_pkg::*; #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [7:0]          req_port_addr_low,
   input  logic [7:0]          req_write_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample_value,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              enable_ff, enable_in;
   logic              csr_wr;
   ctrl_cmd_type      cmd;
   dp_status_type     status;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      ticks_in  = ticks_ff;
      enable_in = enable_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_TICKS:  ticks_in  = pwdata[TICK_W-1:0];
            CSR_ENABLE: enable_in = pwdata[0];
            default:    ticks_in  = ticks_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_TICKS:  prdata = {{(32-TICK_W){1'b0}}, ticks_ff};
         CSR_ENABLE: prdata = {31'b0, enable_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= TICKS_RESET;
         enable_ff <= 1'b1;
      end else begin
         ticks_ff  <= ticks_in;
         enable_ff <= enable_in;
      end
   end

   tcps_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_type         (req_type),
      .ticks_per_sample (ticks_ff),
      .status           (status),
      .req_stall        (req_stall),
      .cmd              (cmd)
   );

   tcps_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .port_addr_low    (req_port_addr_low),
      .write_byte       (req_write_byte),
      .ticks_per_sample (ticks_ff),
      .synth_enable     (enable_ff),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

[hdl/tcps_ctrl.sv]
// Sequencer for port writes and sample generation: tick phase, divide phase, output load.
module tcps_ctrl import tcps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   input  logic [TICK_W-1:0] ticks_per_sample,
   input  dp_status_type     status,
   output logic              req_stall,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_TICK = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [TICK_W-1:0]   tick_cnt_ff, tick_cnt_in;
   logic [DCNT_W-1:0]   div_cnt_ff, div_cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      tick_cnt_in = tick_cnt_ff;
      div_cnt_in  = div_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type) begin
                  cmd.sample_start = 1'b1;
                  tick_cnt_in      = ticks_per_sample;
                  state_in         = S_TICK;
               end else begin
                  cmd.port_wr = 1'b1;
               end
            end
         end
         S_TICK: begin
            if (tick_cnt_ff == '0) begin
               cmd.div_load = 1'b1;
               div_cnt_in   = DIV_STEPS;
               state_in     = S_DIV;
            end else begin
               cmd.tick    = 1'b1;
               tick_cnt_in = tick_cnt_ff - 1'b1;
            end
         end
         S_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = S_OUT;
            end else begin
               cmd.div_step = 1'b1;
               div_cnt_in   = div_cnt_ff - 1'b1;
            end
         end
         S_OUT: begin
            // hold until the output register can take the item
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tick_cnt_ff <= '0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         tick_cnt_ff <= tick_cnt_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

   a_sample_starts_ticking: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type) |=> (state_ff == S_TICK))
      else $error("sample item did not enter tick phase");

   a_div_after_ticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (tick_cnt_ff == '0))
      else $error("divide phase entered with ticks remaining");

   a_out_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (div_cnt_ff == '0))
      else $error("output phase entered with divide steps remaining");

endmodule

[hdl/tcps_dp.sv]
// Channel lanes (divisor latch, counter, square output), per-lane dividers, mixer, output register.
module tcps_dp import tcps_pkg::*; #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic [7:0]          port_addr_low,
   input  logic [7:0]          write_byte,
   input  logic [TICK_W-1:0]   ticks_per_sample,
   input  logic                synth_enable,
   input  logic                rsp_stall,
   output dp_status_type       status,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_sample_value
);

   logic                wr_hit;
   logic [1:0]          port;
   logic [1:0]          ctl_ch;
   logic [QUOT_W-1:0]   lane_quot [NUM_CHANNELS];
   logic [SAMPLE_W-1:0] mix_sum;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;

   assign wr_hit = cmd.port_wr && synth_enable
                   && ((port_addr_low & DECODE_MASK) == DECODE_MATCH);
   assign port   = port_addr_low[6:5];
   assign ctl_ch = write_byte[7:6];

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      logic [7:0]        hold_ff, hold_in;
      logic              pending_ff, pending_in;
      logic [DIV_W-1:0]  divisor_ff, divisor_in;
      logic [DIV_W-1:0]  count_ff, count_in;
      logic              out_ff, out_in;
      logic              active_ff, active_in;
      logic              run_ff, run_in;
      logic [TICK_W-1:0] high_ff, high_in;
      logic [7:0]        rem_ff, rem_in;
      logic [PROD_W-1:0] nq_ff, nq_in;
      logic              ctl_hit, data_hit;
      logic [DIV_W-1:0]  count_inc;
      logic [DIV_W-1:0]  new_divisor;
      logic              wrap;
      logic [8:0]        trial;
      logic              ge;

      assign ctl_hit     = wr_hit && (port == PORT_CTRL) && (ctl_ch == 2'(i));
      assign data_hit    = wr_hit && (port == 2'(i));
      assign new_divisor = {write_byte, hold_ff};
      assign count_inc   = count_ff + 1'b1;
      assign wrap        = (count_inc >= (divisor_ff >> 1));
      assign trial       = {rem_ff, nq_ff[PROD_W-1]};
      assign ge          = (trial >= {1'b0, ticks_per_sample});

      always_comb begin
         hold_in    = hold_ff;
         pending_in = pending_ff;
         divisor_in = divisor_ff;
         count_in   = count_ff;
         out_in     = out_ff;
         active_in  = active_ff;
         run_in     = run_ff;
         high_in    = high_ff;
         rem_in     = rem_ff;
         nq_in      = nq_ff;
         if (ctl_hit) begin
            pending_in = 1'b0;
            count_in   = '0;
            out_in     = 1'b0;
         end else if (data_hit) begin
            if (!pending_ff) begin
               hold_in    = write_byte;
               pending_in = 1'b1;
            end else begin
               divisor_in = new_divisor;
               count_in   = '0;
               out_in     = 1'b1;
               active_in  = (new_divisor >= MIN_DIVISOR);
               pending_in = 1'b0;
            end
         end
         if (cmd.sample_start) begin
            run_in  = active_ff && (divisor_ff >= MIN_DIVISOR) && (ticks_per_sample != '0);
            high_in = '0;
         end
         if (cmd.tick && run_ff) begin
            // wrap at half the divisor and toggle; count the tick after the toggle
            count_in = wrap ? '0 : count_inc;
            out_in   = out_ff ^ wrap;
            high_in  = high_ff + TICK_W'(out_ff ^ wrap);
         end
         if (cmd.div_load) begin
            rem_in = '0;
            nq_in  = PROD_W'(high_ff) * CHANNEL_AMP;
         end
         if (cmd.div_step) begin
            rem_in = ge ? 8'(trial - {1'b0, ticks_per_sample}) : trial[7:0];
            nq_in  = {nq_ff[PROD_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hold_ff    <= '0;
            pending_ff <= 1'b0;
            divisor_ff <= '0;
            count_ff   <= '0;
            out_ff     <= 1'b0;
            active_ff  <= 1'b0;
            run_ff     <= 1'b0;
         end else begin
            hold_ff    <= hold_in;
            pending_ff <= pending_in;
            divisor_ff <= divisor_in;
            count_ff   <= count_in;
            out_ff     <= out_in;
            active_ff  <= active_in;
            run_ff     <= run_in;
         end
      end

      always_ff @(posedge clock) begin
         high_ff <= high_in;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
      end

      // idle lanes contribute nothing
      assign lane_quot[i] = run_ff ? nq_ff[QUOT_W-1:0] : '0;
   end

   always_comb begin
      mix_sum = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         mix_sum = mix_sum + SAMPLE_W'(lane_quot[i]);
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = mix_sum;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.port_wr, cmd.sample_start, cmd.tick, cmd.div_load,
                cmd.div_step, cmd.out_load}))
      else $error("more than one datapath command in a cycle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output item overwritten while stalled");

   a_mix_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (mix_sum <= MAX_SAMPLE))
      else $error("mixed sample out of range");

endmodule

[bench/three_channel_pit_square_synth_top_tb.sv]
// Self-checking testbench for the three-channel square-wave synthesizer top level.
module three_channel_pit_square_synth_top_tb import tcps_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CH        = 3;
   localparam int SETTLE      = 300;
   localparam int LONG_HOLD   = 1000;
   localparam int PHASE_ITEMS = 240;
   localparam int N_PHASES    = 8;

   localparam logic       REQ_PORT_WRITE = 1'b0;
   localparam logic       REQ_SAMPLE     = 1'b1;
   localparam logic [2:0] ADDR_TICKS     = {CSR_TICKS, 2'b00};
   localparam logic [2:0] ADDR_ENABLE    = {CSR_ENABLE, 2'b00};
   localparam logic [7:0] CTRL_ADDR      = DECODE_MATCH | {1'b0, PORT_CTRL, 5'b0};

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] addr;
      logic [7:0] data;
   } synth_item_type;

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic                req_type          = 1'b0;
   logic [7:0]          req_port_addr_low = 8'h00;
   logic [7:0]          req_write_byte    = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [SAMPLE_W-1:0] rsp_sample_value;
   logic                psel              = 1'b0;
   logic                penable           = 1'b0;
   logic                pwrite            = 1'b0;
   logic [2:0]          paddr             = 3'd0;
   logic [31:0]         pwdata            = 32'd0;
   logic [31:0]         prdata;
   logic                pready;

   three_channel_pit_square_synth_top #(.NUM_CHANNELS(N_CH)) u_dut (.*);

   // synthesizer state as predicted
   logic [TICK_W-1:0] cfg_ticks;
   logic              cfg_enable;
   logic [7:0]        held_low    [N_CH];
   logic              low_pending [N_CH];
   logic [DIV_W-1:0]  div_val     [N_CH];
   logic [DIV_W-1:0]  count_val   [N_CH];
   logic              sq_out      [N_CH];
   logic              ch_active   [N_CH];

   synth_item_type      pending_items[$];
   logic [SAMPLE_W-1:0] sample_expect[$];
   synth_item_type      next_item;
   logic [SAMPLE_W-1:0] want_value;
   int                  pushed_items   = 0;
   int                  accepted_items = 0;
   int                  error_count    = 0;
   idle_kind_type       idle_mode      = IDLE_NONE;
   int                  hold_request   = 0;
   int                  hold_served    = 0;
   int                  hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void apply_port_write(logic [7:0] addr, logic [7:0] data);
      logic [1:0] port;
      logic [1:0] sel;
      if (!cfg_enable || (addr & DECODE_MASK) != DECODE_MATCH) return;
      port = addr[6:5];
      if (port == PORT_CTRL) begin
         sel = data[7:6];
         if (sel < N_CH) begin
            low_pending[sel] = 1'b0;
            count_val[sel]   = '0;
            sq_out[sel]      = 1'b0;
         end
         return;
      end
      if (port >= N_CH) return;
      if (!low_pending[port]) begin
         held_low[port]    = data;
         low_pending[port] = 1'b1;
      end else begin
         div_val[port]     = {data, held_low[port]};
         count_val[port]   = '0;
         sq_out[port]      = 1'b1;
         ch_active[port]   = (div_val[port] >= MIN_DIVISOR);
         low_pending[port] = 1'b0;
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] mix_sample();
      int unsigned total, half, high_ticks, cnt, tks;
      logic        lvl;
      total = 0;
      tks   = cfg_ticks;
      for (int ch = 0; ch < N_CH; ch++) begin
         if (!ch_active[ch] || div_val[ch] < MIN_DIVISOR || tks == 0) continue;
         half       = div_val[ch] >> 1;
         cnt        = count_val[ch];
         lvl        = sq_out[ch];
         high_ticks = 0;
         for (int m = 0; m < tks; m++) begin
            cnt = (cnt + 1) & 32'hFFFF;
            if (cnt >= half) begin
               cnt = 0;
               lvl = ~lvl;
            end
            high_ticks += lvl;
         end
         count_val[ch] = cnt[DIV_W-1:0];
         sq_out[ch]    = lvl;
         total += high_ticks * CHANNEL_AMP / tks;
      end
      return total[SAMPLE_W-1:0];
   endfunction

   function automatic int send_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 72;
         IDLE_BOTH:   return 8;
         default:     return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 72;
         IDLE_BOTH:     return 8;
         default:       return 0;
      endcase
   endfunction

   function automatic void add_item(logic kind, logic [7:0] addr, logic [7:0] data);
      synth_item_type it;
      it.kind = kind;
      it.addr = addr;
      it.data = data;
      pending_items.push_back(it);
      pushed_items++;
   endfunction

   function automatic logic [7:0] data_addr(int port);
      return DECODE_MATCH | 8'(port << 5);
   endfunction

   // one short burst of stimulus; returns the number of items added
   function automatic int add_random_group();
      int          r, ch, n;
      logic [15:0] dv;
      r = $urandom_range(0, 99);
      n = 0;
      if (r < 40) begin
         ch = $urandom_range(0, N_CH - 1);
         if ($urandom_range(0, 1)) begin
            add_item(REQ_PORT_WRITE, CTRL_ADDR, {2'(ch), 6'($urandom)});
            n++;
         end
         case ($urandom_range(0, 9))
            0:       dv = 16'($urandom_range(0, 1));
            1:       dv = 16'($urandom);
            default: dv = 16'($urandom_range(2, 600));
         endcase
         add_item(REQ_PORT_WRITE, data_addr(ch), dv[7:0]);
         add_item(REQ_PORT_WRITE, data_addr(ch), dv[15:8]);
         n += 2;
         repeat ($urandom_range(1, 3)) begin
            add_item(REQ_SAMPLE, 8'($urandom), 8'($urandom));
            n++;
         end
      end else if (r < 75) begin
         repeat ($urandom_range(1, 3)) begin
            add_item(REQ_SAMPLE, 8'($urandom), 8'($urandom));
            n++;
         end
      end else if (r < 85) begin
         add_item(REQ_PORT_WRITE, CTRL_ADDR, 8'($urandom));
         n++;
      end else if (r < 95) begin
         add_item(REQ_PORT_WRITE, data_addr($urandom_range(0, N_CH - 1)), 8'($urandom));
         n++;
      end else begin
         add_item(REQ_PORT_WRITE, 8'($urandom), 8'($urandom));
         n++;
      end
      return n;
   endfunction

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_TICKS) cfg_ticks = value[TICK_W-1:0];
      else cfg_enable = value[0];
   endtask

   // wait for all items and results, then let any trailing port write settle
   task automatic wait_drained();
      while (accepted_items != pushed_items || sample_expect.size() != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_type == REQ_SAMPLE) sample_expect.push_back(mix_sample());
            else apply_port_write(req_port_addr_low, req_write_byte);
            accepted_items++;
         end
         // hold a stalled item, otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               next_item = pending_items.pop_front();
               req_valid         <= 1'b1;
               req_type          <= next_item.kind;
               req_port_addr_low <= next_item.addr;
               req_write_byte    <= next_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = LONG_HOLD;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct());
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_expect.size() == 0) begin
            $error("unexpected item: sample_value actual %0d", rsp_sample_value);
            error_count++;
         end else begin
            want_value = sample_expect.pop_front();
            if (rsp_sample_value !== want_value) begin
               $error("sample_value mismatch: expected %0d, actual %0d",
                      want_value, rsp_sample_value);
               error_count++;
            end
         end
      end
   end

   initial begin
      int            n;
      int            tks;
      int            phase_ticks[N_PHASES];
      logic          phase_enable[N_PHASES];
      idle_kind_type phase_idle[N_PHASES];

      phase_ticks  = '{255, 1, 0, 112, 37, -1, -1, 200};
      phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      phase_idle   = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                       IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

      cfg_ticks  = TICKS_RESET;
      cfg_enable = 1'b1;
      for (int ch = 0; ch < N_CH; ch++) begin
         held_low[ch]    = '0;
         low_pending[ch] = 1'b0;
         div_val[ch]     = '0;
         count_val[ch]   = '0;
         sq_out[ch]      = 1'b0;
         ch_active[ch]   = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset configuration
      add_item(REQ_SAMPLE, 8'h00, 8'h00);
      add_item(REQ_PORT_WRITE, CTRL_ADDR, 8'h00);
      add_item(REQ_PORT_WRITE, data_addr(0), 8'h00);
      add_item(REQ_PORT_WRITE, data_addr(0), 8'h00);
      add_item(REQ_SAMPLE, 8'hFF, 8'hFF);
      add_item(REQ_PORT_WRITE, data_addr(1), 8'h01);
      add_item(REQ_PORT_WRITE, data_addr(1), 8'h00);
      add_item(REQ_PORT_WRITE, data_addr(0), 8'h02);
      add_item(REQ_PORT_WRITE, data_addr(0), 8'h00);
      add_item(REQ_PORT_WRITE, data_addr(1), 8'hFF);
      add_item(REQ_PORT_WRITE, data_addr(1), 8'hFF);
      add_item(REQ_PORT_WRITE, data_addr(2), 8'd100);
      add_item(REQ_PORT_WRITE, data_addr(2), 8'h00);
      add_item(REQ_SAMPLE, 8'h00, 8'h00);
      add_item(REQ_PORT_WRITE, CTRL_ADDR, 8'hC0);
      add_item(REQ_PORT_WRITE, CTRL_ADDR, 8'hBF);
      add_item(REQ_SAMPLE, 8'h00, 8'h00);
      add_item(REQ_PORT_WRITE, 8'h0E, 8'hFF);
      add_item(REQ_PORT_WRITE, 8'hFF, 8'hFF);
      add_item(REQ_PORT_WRITE, 8'h8F, 8'h00);
      add_item(REQ_PORT_WRITE, data_addr(2), 8'h33);
      add_item(REQ_PORT_WRITE, CTRL_ADDR, 8'h80);
      add_item(REQ_PORT_WRITE, data_addr(2), 8'h10);
      add_item(REQ_PORT_WRITE, data_addr(2), 8'h01);
      add_item(REQ_SAMPLE, 8'h00, 8'h00);
      wait_drained();

      for (int p = 0; p < N_PHASES; p++) begin
         tks = (phase_ticks[p] < 0) ? $urandom_range(2, 254) : phase_ticks[p];
         write_csr(ADDR_TICKS, 32'(tks));
         write_csr(ADDR_ENABLE, {31'd0, phase_enable[p]});
         idle_mode = phase_idle[p];
         // fill the block: hold off the receiver while items keep coming
         if (p == 4) hold_request++;
         n = 0;
         while (n < PHASE_ITEMS) n += add_random_group();
         wait_drained();
      end

      if (sample_expect.size() != 0) begin
         $error("%0d expected sample items never arrived", sample_expect.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/tcps_pkg.sv
hdl/tcps_ctrl.sv
hdl/tcps_dp.sv
hdl/three_channel_pit_square_synth_top.sv
bench/three_channel_pit_square_synth_top_tb.sv
